/* src/fhl_pkg.sv */
package fhl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 32;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [ID_W-1:0]  t_id;

    typedef enum logic {
        REQ_LOCK   = 1'b0,
        REQ_UNLOCK = 1'b1
    } t_req;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    localparam t_ptr PTR_LAST  = t_ptr'(QUEUE_DEPTH - 1);
    localparam t_cnt CNT_FULL  = t_cnt'(QUEUE_DEPTH);
    localparam t_id  ID_NONE   = '0;

endpackage

/* src/fifo_handoff_lock.sv */
// Lock unit with a first-come waiter queue of fhl_pkg::QUEUE_DEPTH entries. A request is
// taken when start is high and busy is low; its result sits on the o_ ports for exactly
// one cycle with o_strobe high, starting one cycle after the request is taken, and must be
// captured at the edge that ends that cycle, the second edge after the request is taken,
// since the block cannot be stalled. busy stays high for the one cycle after a request
// is taken, so a new request may be taken every second cycle: that cycle waits for the
// registered read of the waiter memory, which holds the ids of queued threads. A lock on a
// free lock grants at once, a lock on a held lock joins the queue or, if the queue is full,
// is dropped with o_queue_full_error; an unlock pops the oldest waiter and hands the lock to
// it (o_wake_valid, o_wake_thread), or frees the lock when nobody waits. Unlock does not check
// the caller. Thread id zero on a lock is ignored.
module fifo_handoff_lock (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_req_type,
    input  fhl_pkg::t_id     i_thread_id,
    output logic             o_strobe,
    output logic             o_granted,
    output logic             o_queued,
    output logic             o_queue_full_error,
    output logic             o_wake_valid,
    output fhl_pkg::t_id     o_wake_thread,
    output fhl_pkg::t_id     o_owner_now
);
    import fhl_pkg::*;

    t_id    r_mem [QUEUE_DEPTH];
    t_id    r_rd_data;

    t_state r_state, n_state;
    t_ptr   r_rd_ptr, n_rd_ptr;
    t_ptr   r_wr_ptr, n_wr_ptr;
    t_cnt   r_count, n_count;
    t_id    r_owner, n_owner;
    logic   r_strobe, n_strobe;

    logic   r_req_type;
    t_id    r_thread_id;

    logic   r_granted, n_granted;
    logic   r_queued, n_queued;
    logic   r_full_err, n_full_err;
    logic   r_wake_valid, n_wake_valid;
    t_id    r_wake_thread, n_wake_thread;
    logic   w_we;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wr_ptr] <= r_thread_id;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_owner  <= ID_NONE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            r_owner  <= n_owner;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req_type  <= i_req_type;
            r_thread_id <= i_thread_id;
        end
        r_granted     <= n_granted;
        r_queued      <= n_queued;
        r_full_err    <= n_full_err;
        r_wake_valid  <= n_wake_valid;
        r_wake_thread <= n_wake_thread;
    end

    always_comb begin
        n_state       = r_state;
        n_rd_ptr      = r_rd_ptr;
        n_wr_ptr      = r_wr_ptr;
        n_count       = r_count;
        n_owner       = r_owner;
        n_strobe      = 1'b0;
        n_granted     = 1'b0;
        n_queued      = 1'b0;
        n_full_err    = 1'b0;
        n_wake_valid  = 1'b0;
        n_wake_thread = ID_NONE;
        w_we          = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state  = ST_IDLE;
                n_strobe = 1'b1;
                if (r_req_type == REQ_LOCK) begin
                    if (r_thread_id != ID_NONE) begin
                        if (r_owner == ID_NONE) begin
                            n_owner   = r_thread_id;
                            n_granted = 1'b1;
                        end else if (r_count >= CNT_FULL) begin
                            n_full_err = 1'b1;
                        end else begin
                            w_we     = 1'b1;
                            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + t_ptr'(1);
                            n_count  = r_count + t_cnt'(1);
                            n_queued = 1'b1;
                        end
                    end
                end else begin
                    if (r_count == '0) begin
                        n_owner = ID_NONE;
                    end else begin
                        n_rd_ptr      = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + t_ptr'(1);
                        n_count       = r_count - t_cnt'(1);
                        n_owner       = r_rd_data;
                        n_wake_valid  = 1'b1;
                        n_wake_thread = r_rd_data;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy               = (r_state != ST_IDLE);
    assign o_strobe           = r_strobe;
    assign o_granted          = r_granted;
    assign o_queued           = r_queued;
    assign o_queue_full_error = r_full_err;
    assign o_wake_valid       = r_wake_valid;
    assign o_wake_thread      = r_wake_thread;
    assign o_owner_now        = r_owner;

endmodule

/* src/fhl_checker.sv */
module fhl_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         start,
    input logic         busy,
    input logic         i_req_type,
    input fhl_pkg::t_id i_thread_id,
    input logic         o_strobe,
    input logic         o_granted,
    input logic         o_queued,
    input logic         o_queue_full_error,
    input logic         o_wake_valid,
    input fhl_pkg::t_id o_wake_thread,
    input fhl_pkg::t_id o_owner_now
);
    import fhl_pkg::*;

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $countones({o_granted, o_queued, o_queue_full_error, o_wake_valid}) <= 1)
        else $error("more than one outcome flag on a result");

    a_wake_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_wake_valid) |-> (o_wake_thread == o_owner_now))
        else $error("woken thread is not the new owner");

    a_grant_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_granted) |-> (o_owner_now != ID_NONE))
        else $error("grant leaves the lock free");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a taken item");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("no result two cycles after a taken item");

endmodule

bind fifo_handoff_lock fhl_checker u_fhl_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
    import fhl_pkg::*;

    typedef struct packed {
        logic granted;
        logic queued;
        logic full_err;
        logic wake_valid;
        t_id  wake_thread;
        t_id  owner_now;
    } t_lock_result;

    class t_lock_scoreboard;
        t_id          waiters[QUEUE_DEPTH];
        t_ptr         rd_ptr   = '0;
        t_ptr         wr_ptr   = '0;
        t_cnt         waiting  = '0;
        t_id          owner_id = ID_NONE;
        t_lock_result pending[$];
        int           mismatches = 0;

        function t_ptr ptr_advance(t_ptr p);
            return (p == PTR_LAST) ? t_ptr'(0) : t_ptr'(p + 1'b1);
        endfunction

        function void note_request(t_req req, t_id id);
            t_lock_result r;
            r = '0;
            if (req == REQ_LOCK) begin
                if (id != ID_NONE) begin
                    if (owner_id == ID_NONE) begin
                        owner_id  = id;
                        r.granted = 1'b1;
                    end else if (waiting == CNT_FULL) begin
                        r.full_err = 1'b1;
                    end else begin
                        waiters[wr_ptr] = id;
                        wr_ptr   = ptr_advance(wr_ptr);
                        waiting  = waiting + 1'b1;
                        r.queued = 1'b1;
                    end
                end
            end else begin
                if (waiting == '0) begin
                    owner_id = ID_NONE;
                end else begin
                    owner_id      = waiters[rd_ptr];
                    rd_ptr        = ptr_advance(rd_ptr);
                    waiting       = waiting - 1'b1;
                    r.wake_valid  = 1'b1;
                    r.wake_thread = owner_id;
                end
            end
            r.owner_now = owner_id;
            pending.push_back(r);
        endfunction

        function void check_result(t_lock_result got);
            t_lock_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: %s g=%0b q=%0b e=%0b w=%0b",
                             $realtime, "actual", got.granted, got.queued, got.full_err,
                             got.wake_valid);
                if (mismatches <= 10)
                    $display("  wt=%h own=%h", got.wake_thread, got.owner_now);
                return;
            end
            want = pending.pop_front();
            if (got.granted !== want.granted || got.queued !== want.queued ||
                got.full_err !== want.full_err || got.wake_valid !== want.wake_valid ||
                got.wake_thread !== want.wake_thread || got.owner_now !== want.owner_now) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch", $realtime);
                    $display("  expected g=%0b q=%0b e=%0b w=%0b wt=%h own=%h",
                             want.granted, want.queued, want.full_err, want.wake_valid,
                             want.wake_thread, want.owner_now);
                    $display("  actual   g=%0b q=%0b e=%0b w=%0b wt=%h own=%h",
                             got.granted, got.queued, got.full_err, got.wake_valid,
                             got.wake_thread, got.owner_now);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n   = 1'b0;
    logic start     = 1'b0;
    logic busy;
    logic req_type  = REQ_LOCK;
    t_id  thread_id = ID_NONE;
    logic o_strobe;
    logic o_granted;
    logic o_queued;
    logic o_queue_full_error;
    logic o_wake_valid;
    t_id  o_wake_thread;
    t_id  o_owner_now;

    t_lock_scoreboard sb;

    fifo_handoff_lock dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_type         (req_type),
        .i_thread_id        (thread_id),
        .o_strobe           (o_strobe),
        .o_granted          (o_granted),
        .o_queued           (o_queued),
        .o_queue_full_error (o_queue_full_error),
        .o_wake_valid       (o_wake_valid),
        .o_wake_thread      (o_wake_thread),
        .o_owner_now        (o_owner_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("** fifo_handoff_lock: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                sb.check_result(t_lock_result'{o_granted, o_queued, o_queue_full_error,
                                               o_wake_valid, o_wake_thread, o_owner_now});
            if (start && !busy)
                sb.note_request(t_req'(req_type), thread_id);
        end
    end

    task automatic send(t_req req, t_id id, int idle_pct);
        start     <= 1'b1;
        req_type  <= req;
        thread_id <= id;
        do @(posedge i_clk); while (busy);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    function automatic t_id pick_id();
        int sel;
        sel = $urandom_range(99);
        if (sel < 3)  return ID_NONE;
        if (sel < 6)  return '1;
        if (sel < 9)  return t_id'(1);
        if (sel < 20) return sb.owner_id;
        return t_id'($urandom);
    endfunction

    initial begin
        int idle_pct [4] = '{0, 49, 0, 19};
        int lock_pcts[3] = '{90, 50, 10};
        int lock_pct;
        int left;
        int burst;

        sb = new;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: free-lock corners, self-relock, ignored zero id, fill to full, overflow, two handoffs
        send(REQ_UNLOCK, t_id'(7), 0);
        send(REQ_LOCK, ID_NONE, 0);
        send(REQ_LOCK, t_id'(1), 0);
        send(REQ_LOCK, t_id'(1), 0);
        send(REQ_LOCK, ID_NONE, 0);
        send(REQ_LOCK, '1, 0);
        for (int k = 0; k < 14; k++)
            send(REQ_LOCK, (k % 2) ? t_id'(32'h5A5A_5A5A ^ k) : t_id'(32'hA5A5_0000 + k), 0);
        send(REQ_LOCK, t_id'(32'h8000_0000), 0);
        send(REQ_UNLOCK, ID_NONE, 0);
        send(REQ_UNLOCK, '1, 0);

        for (int ph = 0; ph < 4; ph++) begin
            left = 200;
            while (left > 0) begin
                lock_pct = lock_pcts[$urandom_range(2)];
                burst    = $urandom_range(1, 40);
                if (burst > left) burst = left;
                for (int n = 0; n < burst; n++) begin
                    if ($urandom_range(99) < lock_pct)
                        send(REQ_LOCK, pick_id(), idle_pct[ph]);
                    else
                        send(REQ_UNLOCK, t_id'($urandom), idle_pct[ph]);
                end
                left -= burst;
            end
        end

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("** fifo_handoff_lock: PASSED **");
        else
            $display("** fifo_handoff_lock: FAILED **");
        $finish;
    end
endmodule
